### sv/wide_arx_block_hash_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wide ARX block hash
// Shorthand for clocked implication checks; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef WIDE_ARX_BLOCK_HASH_MACROS_SVH
`define WIDE_ARX_BLOCK_HASH_MACROS_SVH

// Same-cycle implication
`define AWX_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define AWX_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/awx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awx_pkg
// Constants, types and helpers shared by the wide ARX block hash.
// ----------------------------------------------------------------------------
package awx_pkg;

	localparam logic [63:0] MIX_K [8] = '{
		64'hFFFF_FFFF_FFFF_FFC5,
		64'd13166748625691186689,
		64'd1573836600196043749,
		64'd1478582680485693857,
		64'd1584163446043636637,
		64'd1358537349836140151,
		64'd2849285319520710901,
		64'd2366157163652459183
	};

	localparam int unsigned MIX_ROT [8] = '{17, 19, 23, 29, 31, 37, 41, 53};

	// Lane start offsets over seed plus length
	localparam logic [5:0] START_ADD [16] = '{
		6'd1, 6'd2, 6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
		6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43
	};

	localparam logic [63:0] CTR_L = 64'hEFCD_AB89_6745_2301;
	localparam logic [63:0] CTR_R = 64'h1032_5476_98BA_DCFE;

	// Configuration register indexes
	localparam logic [1:0] CFG_SEED      = 2'd0;
	localparam logic [1:0] CFG_LENGTH    = 2'd1;
	localparam logic [1:0] CFG_OUT_WORDS = 2'd2;

	typedef enum logic [1:0] {
		LOP_HOLD,
		LOP_MIX_L,
		LOP_MIX_R,
		LOP_SUB
	} lane_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_SUB,
		ST_XTRA,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic       in_ready;
		lane_op_t   op;
		logic [2:0] step;
		logic       blk_tail;
		logic       out_load;
		logic [2:0] out_idx;
		logic       out_last;
	} seq_ctrl_t;

	typedef struct packed {
		logic        head;
		logic        wrap;
		logic        pad;
		logic [63:0] word;
		logic [3:0]  cnt;
		logic [5:0]  pos;
		logic [5:0]  pad_from;
	} blk_wr_t;

	typedef struct packed {
		logic [63:0] l0;
		logic [63:0] l1;
		logic [63:0] h0;
		logic [63:0] h1;
	} lane_head_t;

	// Rotate right by the fixed amount that belongs to lane step sel
	function automatic logic [63:0] rotr_sel(input logic [63:0] x, input logic [2:0] sel);
		logic [63:0] y;
		y = x;
		for (int i = 0; i < 8; i++) begin
			if (sel == 3'(i)) begin
				y = (x >> MIX_ROT[i]) | (x << (64 - MIX_ROT[i]));
			end
		end
		return y;
	endfunction

endpackage

### sv/awx_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awx channel interfaces
// Valid/ready channels for message items, digest words and register writes.
// ----------------------------------------------------------------------------
interface awx_item_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last_word;

	modport source (output valid, output data_word, output byte_count, output last_word,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input last_word,
		output ready);
endinterface

interface awx_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [2:0]  word_index;
	logic        last_result;

	modport source (output valid, output digest_word, output word_index, output last_result,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_result,
		output ready);
endinterface

interface awx_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### sv/wide_arx_block_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_arx_block_hash
// Add-xor-rotate block hash over 64-bit message words, 1 to 8 digest words.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    - register writes (seed, message length, digest size); always ready.
//            Write only between messages, once the last digest word is loaded.
//   item   - message words, up to eight bytes each, first byte in bits 7:0.
//            The first item of a message loads the lanes from seed + length.
//   digest - one transfer per digest word, word_index from 0, last_result on
//            the final word.
// Operation:
//   An item that leaves its block open is taken and the block stays ready.
//   An item that closes a 64-byte block starts four rounds of eight lane
//   steps, one step a cycle through the single mix unit. The last item adds
//   the final block, folding of the high lanes into the low ones and extra
//   rounds for wide digests, then one word a cycle loads unless stalled.
// Reset clears the sequencer, the registers (seed 0, length 0, one word) and
// the message state. A stalled receiver holds the digest register; once the
// final word sits there the block takes items of the next message again.
// ----------------------------------------------------------------------------
module wide_arx_block_hash import awx_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	awx_cfg_if.sink      cfg,
	awx_item_if.sink     item,
	awx_digest_if.source digest
);

	// configuration registers
	logic [63:0] seed_q;
	logic [63:0] len_q;
	logic [63:0] base_q;
	logic [3:0]  out_words_q;

	// message state and the item held over a block boundary
	logic        started_q;
	logic [5:0]  bcnt_q;
	logic [63:0] word_q;
	logic [3:0]  cnt_q;
	logic [5:0]  pos_q;
	logic        last_q;

	// lane rings: index 0 is the head that the mix unit works on
	logic [63:0] lane_l_q [8];
	logic [63:0] lane_h_q [8];
	logic [63:0] acc_q;

	// digest output register
	logic        out_valid_q;
	logic [63:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;

	logic        in_fire;
	logic [3:0]  cnt_c;
	logic [5:0]  pos_c;
	logic [6:0]  sum_c;
	logic        out_free;
	seq_ctrl_t   ctrl;
	blk_wr_t     blk_wr;
	logic [63:0] blk_word;
	lane_head_t  head;
	lane_head_t  head_n;
	logic [63:0] acc_n;

	assign cfg.ready = 1'b1;
	assign item.ready = ctrl.in_ready;
	assign in_fire = item.valid && ctrl.in_ready;
	assign out_free = !out_valid_q || digest.ready;

	// clamp the count and place the bytes after what the block holds
	always_comb begin
		cnt_c = (item.byte_count > 4'd8) ? 4'd8 : item.byte_count;
		pos_c = started_q ? bcnt_q : 6'd0;
		sum_c = {1'b0, pos_c} + {3'b000, cnt_c};
	end

	// register writes; keep seed + length ready for the lane start values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= 64'd0;
			len_q       <= 64'd0;
			base_q      <= 64'd0;
			out_words_q <= 4'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SEED: begin
					seed_q <= cfg.data;
					base_q <= cfg.data + len_q;
				end
				CFG_LENGTH: begin
					len_q  <= cfg.data;
					base_q <= seed_q + cfg.data;
				end
				CFG_OUT_WORDS: begin
					out_words_q <= cfg.data[3:0];
				end
				default: begin
					out_words_q <= out_words_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			bcnt_q    <= 6'd0;
		end else if (in_fire) begin
			started_q <= !item.last_word;
			bcnt_q    <= sum_c[5:0];
		end
	end

	// hold the item so the bytes past a block boundary land after the mix
	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q <= item.data_word;
			cnt_q  <= cnt_c;
			pos_q  <= pos_c;
			last_q <= item.last_word;
		end
	end

	// Block writes: at the transfer, the bytes up to the block end and, for a
	// last item that leaves the block open, the padding too. After a full
	// block is mixed, the wrapped bytes and, on the last item, the padding.
	always_comb begin
		blk_wr = '0;
		if (in_fire) begin
			blk_wr.head     = 1'b1;
			blk_wr.word     = item.data_word;
			blk_wr.cnt      = cnt_c;
			blk_wr.pos      = pos_c;
			blk_wr.pad      = item.last_word && !sum_c[6];
			blk_wr.pad_from = sum_c[5:0];
		end else if (ctrl.blk_tail) begin
			blk_wr.wrap     = 1'b1;
			blk_wr.word     = word_q;
			blk_wr.cnt      = cnt_q;
			blk_wr.pos      = pos_q;
			blk_wr.pad      = last_q;
			blk_wr.pad_from = bcnt_q;
		end
	end

	awx_block_buf u_block_buf (
		.clk     (clk),
		.wr      (blk_wr),
		.rd_idx  (ctrl.step),
		.rd_word (blk_word)
	);

	awx_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_last   (item.last_word),
		.blk_full  (sum_c[6]),
		.pend_last (last_q),
		.out_free  (out_free),
		.out_words (out_words_q),
		.ctrl      (ctrl)
	);

	always_comb begin
		head.l0 = lane_l_q[0];
		head.l1 = lane_l_q[1];
		head.h0 = lane_h_q[0];
		head.h1 = lane_h_q[1];
	end

	awx_mix_unit u_mix_unit (
		.op       (ctrl.op),
		.step     (ctrl.step),
		.blk_word (blk_word),
		.acc      (acc_q),
		.head     (head),
		.head_n   (head_n),
		.acc_n    (acc_n)
	);

	// Load the lanes at the first transfer of a message. Each lane step
	// updates the heads and advances both rings by one, so eight steps bring
	// every lane back to its home slot.
	always_ff @(posedge clk) begin
		if (in_fire && !started_q) begin
			for (int i = 0; i < 8; i++) begin
				lane_l_q[i] <= base_q + {58'd0, START_ADD[i]};
				lane_h_q[i] <= base_q + {58'd0, START_ADD[i + 8]};
			end
		end else if (ctrl.op != LOP_HOLD) begin
			lane_l_q[0] <= head_n.l1;
			lane_h_q[0] <= head_n.h1;
			for (int i = 1; i < 7; i++) begin
				lane_l_q[i] <= lane_l_q[i + 1];
				lane_h_q[i] <= lane_h_q[i + 1];
			end
			lane_l_q[7] <= head_n.l0;
			lane_h_q[7] <= head_n.h0;
		end
		if ((ctrl.op == LOP_MIX_L) || (ctrl.op == LOP_MIX_R)) begin
			acc_q <= acc_n;
		end
	end

	// digest register: load the next low lane when free, drop valid on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (digest.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_word_q <= lane_l_q[ctrl.out_idx];
			out_idx_q  <= ctrl.out_idx;
			out_last_q <= ctrl.out_last;
		end
	end

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_idx_q;
	assign digest.last_result = out_last_q;

endmodule

### sv/awx_block_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awx_block_buf
// 64-byte block store with byte-granular packing, padding and a word read port.
// ----------------------------------------------------------------------------
module awx_block_buf import awx_pkg::*; (
	input  logic        clk,
	input  blk_wr_t     wr,
	input  logic [2:0]  rd_idx,
	output logic [63:0] rd_word
);

	logic [63:0] blk_q [8];
	logic        byte_we  [64];
	logic [7:0]  byte_val [64];
	logic [7:0]  fill;

	always_comb begin
		logic [5:0] d;
		logic       hit;
		logic       above;
		fill = 8'h80 + {2'b00, wr.pad_from};
		for (int p = 0; p < 64; p++) begin
			d     = 6'(p) - wr.pos;
			hit   = d < {2'b00, wr.cnt};
			above = 6'(p) >= wr.pos;
			if (hit && ((wr.head && above) || (wr.wrap && !above))) begin
				byte_we[p]  = 1'b1;
				byte_val[p] = wr.word[{d[2:0], 3'b000} +: 8];
			end else if (wr.pad && (6'(p) >= wr.pad_from)) begin
				byte_we[p]  = 1'b1;
				byte_val[p] = fill;
			end else begin
				byte_we[p]  = 1'b0;
				byte_val[p] = fill;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < 64; p++) begin
			if (byte_we[p]) begin
				blk_q[3'(p >> 3)][8 * (p & 7) +: 8] <= byte_val[p];
			end
		end
	end

	assign rd_word = blk_q[rd_idx];

endmodule

### sv/awx_mix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awx_mix_unit
// Shared lane step: ingest, subtract, rotate, cross-xor and counter chain.
// ----------------------------------------------------------------------------
module awx_mix_unit import awx_pkg::*; (
	input  lane_op_t    op,
	input  logic [2:0]  step,
	input  logic [63:0] blk_word,
	input  logic [63:0] acc,
	input  lane_head_t  head,
	output lane_head_t  head_n,
	output logic [63:0] acc_n
);

	logic [63:0] src;
	logic [63:0] v;
	logic [63:0] acc_base;

	always_comb begin
		src      = (op == LOP_MIX_R) ? head.h0 : head.l0;
		v        = rotr_sel((src ^ blk_word) - MIX_K[step], step);
		acc_base = (step == 3'd0) ? ((op == LOP_MIX_R) ? CTR_R : CTR_L) : acc;
		acc_n    = acc_base + v;
		head_n   = head;
		case (op)
			LOP_MIX_L: begin
				head_n.l0 = v;
				head_n.h0 = head.h0 ^ v;
				// the last left step feeds the first high lane
				if (step == 3'd7) begin
					head_n.h1 = head.h1 - acc_n;
				end else begin
					head_n.l1 = head.l1 - acc_n;
				end
			end
			LOP_MIX_R: begin
				head_n.h0 = v;
				head_n.l0 = head.l0 ^ v;
				head_n.h1 = head.h1 - acc_n;
			end
			LOP_SUB: begin
				head_n.l0 = head.l0 - head.h0;
			end
			default: begin
				head_n = head;
			end
		endcase
	end

endmodule

### sv/awx_seq.sv
`timescale 1ns / 1ps
`include "wide_arx_block_hash_macros.svh"
// ----------------------------------------------------------------------------
// awx_seq
// Sequencer for block mixing, lane folding, extra rounds and digest readout.
// ----------------------------------------------------------------------------
module awx_seq import awx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      in_last,
	input  logic      blk_full,
	input  logic      pend_last,
	input  logic      out_free,
	input  logic [3:0] out_words,
	output seq_ctrl_t ctrl
);

	seq_state_t state_q, state_d;
	logic [2:0] step_q;
	logic [1:0] round_q;
	logic [3:0] xround_q;
	logic [2:0] widx_q;
	logic       final_q;

	logic [3:0] eff;
	logic [3:0] extra;
	logic [2:0] nout_m1;
	logic       step_end;
	logic       mix_end;
	logic       xtra_end;

	always_comb begin
		eff      = (out_words == 4'd0) ? 4'd1 : out_words;
		extra    = (eff > 4'd1) ? eff : 4'd0;
		nout_m1  = (eff > 4'd8) ? 3'd7 : 3'(eff - 4'd1);
		step_end = step_q == 3'd7;
		mix_end  = step_end && (round_q == 2'd3);
		xtra_end = step_end && (xround_q == (extra - 4'd1));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (blk_full || in_last)) begin
					state_d = ST_MIX;
				end
			end
			ST_MIX: begin
				if (mix_end) begin
					if (final_q) begin
						state_d = ST_SUB;
					end else if (pend_last) begin
						state_d = ST_MIX;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SUB: begin
				if (step_end) begin
					state_d = (extra != 4'd0) ? ST_XTRA : ST_OUT;
				end
			end
			ST_XTRA: begin
				if (xtra_end) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free && (widx_q == nout_m1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		ctrl          = '0;
		ctrl.op       = LOP_HOLD;
		ctrl.step     = step_q;
		ctrl.out_idx  = widx_q;
		ctrl.out_last = widx_q == nout_m1;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
			end
			ST_MIX: begin
				ctrl.op       = round_q[0] ? LOP_MIX_L : LOP_MIX_R;
				ctrl.blk_tail = mix_end && !final_q;
			end
			ST_SUB: begin
				ctrl.op = LOP_SUB;
			end
			ST_XTRA: begin
				ctrl.op = LOP_MIX_L;
			end
			ST_OUT: begin
				ctrl.out_load = out_free;
			end
			default: begin
				ctrl.op = LOP_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= 3'd0;
			round_q  <= 2'd0;
			xround_q <= 4'd0;
			widx_q   <= 3'd0;
			final_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.op != LOP_HOLD) begin
				step_q <= step_q + 3'd1;
			end
			if ((state_q == ST_MIX) && step_end) begin
				round_q <= round_q + 2'd1;
			end
			if ((state_q == ST_XTRA) && step_end) begin
				xround_q <= xtra_end ? 4'd0 : xround_q + 4'd1;
			end
			if (ctrl.out_load) begin
				widx_q <= ctrl.out_last ? 3'd0 : widx_q + 3'd1;
			end
			if (in_fire) begin
				final_q <= !blk_full;
			end else if (ctrl.blk_tail && pend_last) begin
				final_q <= 1'b1;
			end
		end
	end

	`AWX_ASSERT_IMP(a_ready_quiet, ctrl.in_ready, (ctrl.op == LOP_HOLD) && !ctrl.out_load, "lanes or digest active while taking items")
	`AWX_ASSERT_NXT(a_step_advance, ctrl.op != LOP_HOLD, step_q == ($past(step_q) + 3'd1), "lane step counter skipped")
	`AWX_ASSERT_NXT(a_final_follows, ctrl.blk_tail && pend_last, (state_q == ST_MIX) && final_q && (round_q == 2'd0) && (step_q == 3'd0), "final block mix not started cleanly")
	`AWX_ASSERT_NXT(a_readout_done, ctrl.out_load && ctrl.out_last, (state_q == ST_IDLE) && (widx_q == 3'd0), "digest readout did not wrap up")

endmodule

### sim/wide_arx_block_hash_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_arx_block_hash_tb
// Self-checking bench for the wide add-xor-rotate block hash. Messages go in
// as random and hand-picked word sequences. A software copy of the lane
// arithmetic predicts each digest word when its message closes. Every digest
// transfer is checked field by field, in order, under varying idle and stall
// patterns on both channels.
// ----------------------------------------------------------------------------
module wide_arx_block_hash_tb import awx_pkg::*; ();

	// Generous ceiling on the length of a run for the watchdog
	localparam int unsigned CYCLE_LIMIT   = 400000;
	// Quiet time after the last digest word before touching the registers
	localparam int unsigned SETTLE_CYCLES = 64;

	// Round constants, rotation amounts, lane offsets and chain counters
	localparam logic [63:0] ROUND_K [8] = '{
		64'hFFFF_FFFF_FFFF_FFC5,
		64'd13166748625691186689,
		64'd1573836600196043749,
		64'd1478582680485693857,
		64'd1584163446043636637,
		64'd1358537349836140151,
		64'd2849285319520710901,
		64'd2366157163652459183
	};
	localparam int unsigned ROUND_ROT [8] = '{17, 19, 23, 29, 31, 37, 41, 53};
	localparam logic [63:0] LANE_OFFSET [16] = '{
		64'd1, 64'd2, 64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
		64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37, 64'd41, 64'd43
	};
	localparam logic [63:0] LEFT_CHAIN  = 64'hEFCD_AB89_6745_2301;
	localparam logic [63:0] RIGHT_CHAIN = 64'h1032_5476_98BA_DCFE;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  word_index;
		logic        last_result;
	} digest_t;

	logic clk = 1'b0;
	logic arst_n;

	awx_item_if   item_ch ();
	awx_digest_if digest_ch ();
	awx_cfg_if    cfg_ch ();

	wide_arx_block_hash dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.digest (digest_ch)
	);

	// Mirror of the hash state and its registers
	logic [63:0] hash_lanes [16];
	logic [63:0] block_words [8] = '{default: 64'd0};
	int unsigned block_fill = 0;
	bit          message_open = 1'b0;
	logic [63:0] seed_reg = 64'd0;
	logic [63:0] length_reg = 64'd0;
	logic [3:0]  words_reg = 4'd1;

	// Digest words still owed by the block, oldest first
	digest_t     pending_digests [$];

	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic logic [63:0] rotate_right(input logic [63:0] x, input int unsigned r);
		return (x >> r) | (x << (64 - r));
	endfunction

	// One round of eight chained lane steps; the left side ingests into the
	// low lanes and cross-xors into the high ones, the right side the reverse
	function automatic void mix_round(input bit left_side);
		logic [63:0] acc;
		logic [63:0] v;
		acc = left_side ? LEFT_CHAIN : RIGHT_CHAIN;
		for (int n = 0; n < 8; n++) begin
			if (left_side) begin
				v = rotate_right((hash_lanes[n] ^ block_words[n]) - ROUND_K[n], ROUND_ROT[n]);
				hash_lanes[n] = v;
				hash_lanes[n + 8] ^= v;
				acc += v;
				hash_lanes[n + 1] -= acc;
			end else begin
				v = rotate_right((hash_lanes[n + 8] ^ block_words[n]) - ROUND_K[n],
					ROUND_ROT[n]);
				hash_lanes[n + 8] = v;
				hash_lanes[n] ^= v;
				acc += v;
				hash_lanes[((n + 1) % 8) + 8] -= acc;
			end
		end
	endfunction

	// Right, left, right, left
	function automatic void mix_block();
		for (int r = 0; r < 4; r++)
			mix_round(r % 2 == 1);
	endfunction

	function automatic void store_byte(input int unsigned pos, input logic [7:0] b);
		block_words[pos / 8][(pos % 8) * 8 +: 8] = b;
	endfunction

	// Advance the mirror by one accepted item and queue any digest words due
	function automatic void predict_item(input logic [63:0] word, input logic [3:0] count,
		input logic is_last);
		int unsigned used;
		int unsigned width;
		int unsigned nout;
		logic [7:0]  pad;
		digest_t     d;
		if (!message_open) begin
			for (int n = 0; n < 16; n++)
				hash_lanes[n] = seed_reg + length_reg + LANE_OFFSET[n];
			block_fill = 0;
			message_open = 1'b1;
		end
		// Counts above eight take the whole word
		used = (count > 4'd8) ? 8 : count;
		for (int b = 0; b < used; b++) begin
			store_byte(block_fill, word[8 * b +: 8]);
			block_fill++;
			if (block_fill >= 64) begin
				mix_block();
				block_fill = 0;
			end
		end
		if (!is_last)
			return;
		// Closing block, possibly empty; pad the tail with 0x80 plus the fill
		pad = 8'h80 + 8'(block_fill);
		for (int n = block_fill; n < 64; n++)
			store_byte(n, pad);
		mix_block();
		for (int n = 0; n < 8; n++)
			hash_lanes[n] -= hash_lanes[n + 8];
		// Size zero means one word; wide sizes run that many extra left rounds
		width = (words_reg == 4'd0) ? 1 : words_reg;
		if (width > 1)
			repeat (width) mix_round(1'b1);
		nout = (width > 8) ? 8 : width;
		for (int n = 0; n < nout; n++) begin
			d.digest_word = hash_lanes[n];
			d.word_index  = 3'(n);
			d.last_result = (n + 1 == nout);
			pending_digests.push_back(d);
		end
		message_open = 1'b0;
		block_fill = 0;
	endfunction

	// ------------------------------------------------------------------------
	// Digest sink: check each transfer, then pick the next ready at random
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : check_digests
		digest_t want;
		if (arst_n && digest_ch.valid && digest_ch.ready) begin
			if (pending_digests.size() == 0) begin
				$error("unexpected digest transfer: word %h index %0d",
					digest_ch.digest_word, digest_ch.word_index);
				fail_count++;
			end else begin
				want = pending_digests.pop_front();
				if (digest_ch.digest_word !== want.digest_word) begin
					$error("digest_word: expected %h, got %h",
						want.digest_word, digest_ch.digest_word);
					fail_count++;
				end
				if (digest_ch.word_index !== want.word_index) begin
					$error("word_index: expected %0d, got %0d",
						want.word_index, digest_ch.word_index);
					fail_count++;
				end
				if (digest_ch.last_result !== want.last_result) begin
					$error("last_result: expected %0b, got %0b",
						want.last_result, digest_ch.last_result);
					fail_count++;
				end
			end
		end
		digest_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: drop the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly random, with the all-zero and all-one extremes now and then
	function automatic logic [63:0] rand_reg_value();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return '1;
			default: return rand64();
		endcase
	endfunction

	// Send one message word. Valid stays high into the next transfer unless
	// the random idle draw holds it low first.
	task automatic send_item(input logic [63:0] word, input logic [3:0] count,
		input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.data_word  <= word;
		item_ch.byte_count <= count;
		item_ch.last_word  <= is_last;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predict_item(word, count, is_last);
	endtask

	// Drop the item channel and wait until every owed digest word has arrived
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back once the block is idle. The
	// digest size register gets random upper bits, which the block must drop.
	task automatic write_config(input logic [63:0] seed_val, input logic [63:0] length_val,
		input logic [3:0] words_val);
		logic [1:0]  idx;
		logic [63:0] val;
		settle();
		for (int i = 0; i < 3; i++) begin
			case (i)
				0: begin
					idx = CFG_SEED;
					val = seed_val;
				end
				1: begin
					idx = CFG_LENGTH;
					val = length_val;
				end
				default: begin
					idx = CFG_OUT_WORDS;
					val = rand64();
					val[3:0] = words_val;
				end
			endcase
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx;
			cfg_ch.data  <= val;
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			case (idx)
				CFG_SEED:      seed_reg = val;
				CFG_LENGTH:    length_reg = val;
				CFG_OUT_WORDS: words_reg = val[3:0];
				default:       ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Whole random messages until the item budget is spent. Most messages
	// are short; some span several blocks. Odd counts turn up both mid
	// message and on the closing word.
	task automatic run_messages(input int unsigned item_budget);
		int unsigned sent;
		int unsigned span;
		int unsigned pick;
		logic [3:0]  count;
		sent = 0;
		while (sent < item_budget) begin
			if ($urandom_range(5) == 0)
				write_config(rand_reg_value(), rand_reg_value(),
					($urandom_range(2) == 0) ? 4'($urandom_range(15))
						: 4'(1 << $urandom_range(3)));
			pick = $urandom_range(99);
			if (pick < 50)
				span = $urandom_range(1, 3);
			else if (pick < 85)
				span = $urandom_range(4, 10);
			else
				span = $urandom_range(11, 24);
			for (int k = 0; k < span; k++) begin
				if (k + 1 < span)
					count = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
				else
					count = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
						: 4'($urandom_range(8));
				send_item(rand64(), count, k + 1 == span);
			end
			sent += span;
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed_cases();
		logic [3:0] odd_sizes [8] = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd15};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// Empty message under the reset registers: the final block is all padding
		send_item(64'd0, 4'd0, 1'b1);
		// All-ones seed, length and data, eight digest words; the message exactly
		// fills one block, so a second block of pure 0x80 padding follows it
		write_config('1, '1, 4'd8);
		for (int i = 0; i < 8; i++)
			send_item('1, 4'd8, i == 7);
		// Digest size zero, a count above eight, a short word mid message, and
		// a length register that disagrees with the bytes actually sent
		write_config(64'd0, 64'd5, 4'd0);
		send_item(64'd0, 4'd15, 1'b0);
		send_item(rand64(), 4'd3, 1'b0);
		send_item(rand64(), 4'd8, 1'b0);
		send_item(rand64(), 4'd1, 1'b1);
		// Further digest sizes: powers of two, odd sizes and above eight
		foreach (odd_sizes[i]) begin
			write_config(rand64(), rand64(), odd_sizes[i]);
			send_item(rand64(), 4'($urandom_range(15)), 1'b1);
		end
	endtask

	task automatic test_streaming();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_messages(80);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 77;
		recv_stall_pct = 0;
		run_messages(80);
	endtask

	task automatic test_receiver_stalls();
		send_idle_pct = 0;
		recv_stall_pct = 77;
		run_messages(80);
	endtask

	task automatic test_mixed_idling();
		send_idle_pct = 34;
		recv_stall_pct = 34;
		run_messages(80);
	endtask

	initial begin
		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.data_word  <= 64'd0;
		item_ch.byte_count <= 4'd0;
		item_ch.last_word  <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_SEED;
		cfg_ch.data        <= 64'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();

		// Let the last digest words drain before judging
		settle();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
